@@ rtl/scc_pkg.sv @@
// Shared types and constants of the strongly connected components block.
`default_nettype none
package scc_pkg;
  localparam int NODES = 64;
  localparam int EDGES = 512;
  localparam int NW    = 6;   // node id bits
  localparam int EAW   = 9;   // edge table address bits
  localparam int ECW   = 10;  // edge count bits
  localparam int NCW   = 7;   // node count bits
  localparam int PAIRS = NODES * NODES;
  localparam int PAW   = 2 * NW;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_ADD     = 3'd1,
    OP_COMPUTE = 3'd2,
    OP_ROOT    = 3'd3,
    OP_ORDER   = 3'd4,
    OP_COND    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_INDEX = 2'd2
  } status_t;

  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_DEDUP      = 1'b1;

  typedef struct packed {
    logic [2:0] opcode;
    logic [5:0] edge_src;
    logic [5:0] edge_dst;
    logic [8:0] query_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] node_a;
    logic [5:0] node_b;
    logic [6:0] component_count;
    logic [9:0] cond_edge_count;
  } out_item_t;
endpackage
`default_nettype wire

@@ rtl/scc_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/strongly_connected_components.sv @@
// Top level: edge table, Kosaraju sequencer over RAM-held lists, and query reads.
//
// Clear, add-edge and read items are taken one per cycle while busy is low; each result
// shows on out_valid for one cycle, registered in qv_r and then out_valid_r after its item
// is accepted, and the receiver cannot stall it. A compute item holds busy high while a
// single sequencer walks RAM-resident lists: it builds the forward and reverse adjacency
// (both passes over the loaded edges), clears the 4096-entry pair bitmap when duplicate
// removal is on, runs the two depth-first walks and gathers condensation edges. Each
// edge step spans more than one state because every list entry is a registered RAM read
// followed by a read-modify-write of a cursor or a root entry.
`default_nettype none
module strongly_connected_components (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire scc_pkg::in_item_t   in_item,
  output logic                     out_valid,
  output scc_pkg::out_item_t       out_item,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [6:0]          cfg_wdata
);
  typedef enum logic [24:0] {
    S_IDLE    = 25'h0000001,
    S_CCLR    = 25'h0000002,
    S_CNT_A   = 25'h0000004,
    S_CNT_B   = 25'h0000008,
    S_CNT_C   = 25'h0000010,
    S_PFX_A   = 25'h0000020,
    S_PFX_B   = 25'h0000040,
    S_FIL_A   = 25'h0000080,
    S_FIL_B   = 25'h0000100,
    S_FIL_C   = 25'h0000200,
    S_PCLR    = 25'h0000400,
    S_OUTF    = 25'h0000800,
    S_OUTR_A  = 25'h0001000,
    S_OUTR_B  = 25'h0002000,
    S_W_TOP   = 25'h0004000,
    S_W_TGT   = 25'h0008000,
    S_W_PUSH  = 25'h0010000,
    S_W_POP   = 25'h0020000,
    S_C_NODE  = 25'h0040000,
    S_C_NODE2 = 25'h0080000,
    S_C_EDGE  = 25'h0100000,
    S_C_DST   = 25'h0200000,
    S_C_CMP   = 25'h0400000,
    S_C_PAIR  = 25'h0800000,
    S_DONE    = 25'h1000000
  } state_t;

  localparam int NW  = scc_pkg::NW;
  localparam int EAW = scc_pkg::EAW;
  localparam int ECW = scc_pkg::ECW;
  localparam int NCW = scc_pkg::NCW;
  localparam int PAW = scc_pkg::PAW;
  localparam int SKW = NW + 2 * ECW;

  // Registers
  state_t               state_r, state_nxt;
  logic [NCW-1:0]       node_count_r, node_count_nxt;
  logic                 dedup_r, dedup_nxt;
  logic [ECW-1:0]       edges_r, edges_nxt;
  logic [NCW-1:0]       comp_r, comp_nxt;
  logic [ECW-1:0]       cond_r, cond_nxt;
  logic [NCW-1:0]       ncomp_r, ncomp_nxt;
  logic                 rev_r, rev_nxt;
  logic [NCW-1:0]       idx_r, idx_nxt;
  logic [ECW-1:0]       e_r, e_nxt;
  logic [ECW-1:0]       acc_r, acc_nxt;
  logic [ECW-1:0]       total_r, total_nxt;
  logic [NW-1:0]        key_r, key_nxt;
  logic [NW-1:0]        s_r, s_nxt;
  logic [NW-1:0]        d_r, d_nxt;
  logic [NCW-1:0]       j_r, j_nxt;
  logic [NCW-1:0]       fcount_r, fcount_nxt;
  logic [scc_pkg::NODES-1:0] vis_r, vis_nxt;
  logic [NCW-1:0]       sp_r, sp_nxt;
  logic [NW-1:0]        tos_v_r, tos_v_nxt;
  logic [ECW-1:0]       tos_pos_r, tos_pos_nxt;
  logic [ECW-1:0]       tos_end_r, tos_end_nxt;
  logic [NW-1:0]        root_r, root_nxt;
  logic [NW-1:0]        rv_r, rv_nxt;
  logic [NW-1:0]        ru_r, ru_nxt;
  logic [ECW-1:0]       p_r, p_nxt;
  logic [ECW-1:0]       pend_r, pend_nxt;
  logic [PAW:0]         pclr_r, pclr_nxt;
  logic                 qv_r, qv_nxt;
  logic [2:0]           qop_r, qop_nxt;
  scc_pkg::status_t     qst_r, qst_nxt;
  logic [NCW-1:0]       qcc_r, qcc_nxt;
  logic [ECW-1:0]       qce_r, qce_nxt;
  logic                 out_valid_r, out_valid_nxt;
  scc_pkg::out_item_t   out_r, out_nxt;

  // RAM ports
  logic                 edge_we, fwd_we, rev_we, cur_we, frng_we, rrng_we;
  logic                 fin_we, root_we, topo_we, stk_we, cond_we, pair_we;
  logic [EAW-1:0]       edge_wa, edge_ra, fwd_wa, fwd_ra, rev_wa, rev_ra, cond_wa, cond_ra;
  logic [NW-1:0]        cur_wa, cur_ra, frng_wa, frng_ra, rrng_wa, rrng_ra;
  logic [NW-1:0]        fin_wa, fin_ra, root_wa, root_ra, topo_wa, topo_ra, stk_wa, stk_ra;
  logic [PAW-1:0]       pair_wa, pair_ra;
  logic [2*NW-1:0]      edge_wd, edge_rd, fwd_wd, fwd_rd, cond_wd, cond_rd;
  logic [NW-1:0]        rev_wd, rev_rd, fin_wd, fin_rd, root_wd, root_rd, topo_wd, topo_rd;
  logic [ECW-1:0]       cur_wd, cur_rd;
  logic [2*ECW-1:0]     frng_wd, frng_rd, rrng_wd, rrng_rd;
  logic [SKW-1:0]       stk_wd, stk_rd;
  logic                 pair_wd, pair_rd;

  scc_ram #(.WIDTH(2*NW),  .DEPTH(scc_pkg::EDGES)) u_edge (.clk(clk), .we(edge_we),
    .waddr(edge_wa), .wdata(edge_wd), .raddr(edge_ra), .rdata(edge_rd));
  scc_ram #(.WIDTH(2*NW),  .DEPTH(scc_pkg::EDGES)) u_fwd (.clk(clk), .we(fwd_we),
    .waddr(fwd_wa), .wdata(fwd_wd), .raddr(fwd_ra), .rdata(fwd_rd));
  scc_ram #(.WIDTH(NW),    .DEPTH(scc_pkg::EDGES)) u_rev (.clk(clk), .we(rev_we),
    .waddr(rev_wa), .wdata(rev_wd), .raddr(rev_ra), .rdata(rev_rd));
  scc_ram #(.WIDTH(2*NW),  .DEPTH(scc_pkg::EDGES)) u_cond (.clk(clk), .we(cond_we),
    .waddr(cond_wa), .wdata(cond_wd), .raddr(cond_ra), .rdata(cond_rd));
  scc_ram #(.WIDTH(ECW),   .DEPTH(scc_pkg::NODES)) u_cur (.clk(clk), .we(cur_we),
    .waddr(cur_wa), .wdata(cur_wd), .raddr(cur_ra), .rdata(cur_rd));
  scc_ram #(.WIDTH(2*ECW), .DEPTH(scc_pkg::NODES)) u_frng (.clk(clk), .we(frng_we),
    .waddr(frng_wa), .wdata(frng_wd), .raddr(frng_ra), .rdata(frng_rd));
  scc_ram #(.WIDTH(2*ECW), .DEPTH(scc_pkg::NODES)) u_rrng (.clk(clk), .we(rrng_we),
    .waddr(rrng_wa), .wdata(rrng_wd), .raddr(rrng_ra), .rdata(rrng_rd));
  scc_ram #(.WIDTH(NW),    .DEPTH(scc_pkg::NODES)) u_fin (.clk(clk), .we(fin_we),
    .waddr(fin_wa), .wdata(fin_wd), .raddr(fin_ra), .rdata(fin_rd));
  scc_ram #(.WIDTH(NW),    .DEPTH(scc_pkg::NODES)) u_root (.clk(clk), .we(root_we),
    .waddr(root_wa), .wdata(root_wd), .raddr(root_ra), .rdata(root_rd));
  scc_ram #(.WIDTH(NW),    .DEPTH(scc_pkg::NODES)) u_topo (.clk(clk), .we(topo_we),
    .waddr(topo_wa), .wdata(topo_wd), .raddr(topo_ra), .rdata(topo_rd));
  scc_ram #(.WIDTH(SKW),   .DEPTH(scc_pkg::NODES)) u_stk (.clk(clk), .we(stk_we),
    .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));
  scc_ram #(.WIDTH(1),     .DEPTH(scc_pkg::PAIRS)) u_pair (.clk(clk), .we(pair_we),
    .waddr(pair_wa), .wdata(pair_wd), .raddr(pair_ra), .rdata(pair_rd));

  logic [NCW-1:0] n_act;
  logic           accept;
  logic [ECW-1:0] lim;
  logic [NW-1:0]  cnt_key, fil_s, fil_d, tgt_u;
  logic           cnt_ok;
  logic [2*ECW-1:0] rng_rd;

  assign n_act  = (node_count_r > NCW'(scc_pkg::NODES)) ? NCW'(scc_pkg::NODES)
                                                        : node_count_r;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign lim    = rev_r ? total_r : edges_r;
  assign fil_s  = rev_r ? fwd_rd[2*NW-1:NW] : edge_rd[2*NW-1:NW];
  assign fil_d  = rev_r ? fwd_rd[NW-1:0] : edge_rd[NW-1:0];
  // The forward pass counts by source, the reverse pass by destination.
  assign cnt_key = rev_r ? fil_d : fil_s;
  assign cnt_ok  = rev_r || (({1'b0, fil_s} < n_act) && ({1'b0, fil_d} < n_act));
  assign tgt_u   = rev_r ? rev_rd : fwd_rd[NW-1:0];
  assign rng_rd  = rev_r ? rrng_rd : frng_rd;

  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = node_count_r;
    dedup_nxt      = dedup_r;
    edges_nxt      = edges_r;
    comp_nxt       = comp_r;
    cond_nxt       = cond_r;
    ncomp_nxt      = ncomp_r;
    rev_nxt        = rev_r;
    idx_nxt        = idx_r;
    e_nxt          = e_r;
    acc_nxt        = acc_r;
    total_nxt      = total_r;
    key_nxt        = key_r;
    s_nxt          = s_r;
    d_nxt          = d_r;
    j_nxt          = j_r;
    fcount_nxt     = fcount_r;
    vis_nxt        = vis_r;
    sp_nxt         = sp_r;
    tos_v_nxt      = tos_v_r;
    tos_pos_nxt    = tos_pos_r;
    tos_end_nxt    = tos_end_r;
    root_nxt       = root_r;
    rv_nxt         = rv_r;
    ru_nxt         = ru_r;
    p_nxt          = p_r;
    pend_nxt       = pend_r;
    pclr_nxt       = pclr_r;
    qv_nxt         = 1'b0;
    qop_nxt        = qop_r;
    qst_nxt        = qst_r;
    qcc_nxt        = qcc_r;
    qce_nxt        = qce_r;

    edge_we = 1'b0; edge_wa = edges_r[EAW-1:0]; edge_wd = {in_item.edge_src, in_item.edge_dst};
    edge_ra = e_r[EAW-1:0];
    fwd_we = 1'b0; fwd_wa = cur_rd[EAW-1:0]; fwd_wd = {s_r, d_r}; fwd_ra = e_r[EAW-1:0];
    rev_we = 1'b0; rev_wa = cur_rd[EAW-1:0]; rev_wd = s_r; rev_ra = tos_pos_r[EAW-1:0];
    cond_we = 1'b0; cond_wa = cond_r[EAW-1:0]; cond_wd = {rv_r, ru_r};
    cond_ra = in_item.query_index[EAW-1:0];
    cur_we = 1'b0; cur_wa = key_r; cur_wd = cur_rd + ECW'(1); cur_ra = idx_r[NW-1:0];
    frng_we = 1'b0; frng_wa = idx_r[NW-1:0]; frng_wd = {acc_r, acc_r + cur_rd};
    frng_ra = idx_r[NW-1:0];
    rrng_we = 1'b0; rrng_wa = idx_r[NW-1:0]; rrng_wd = {acc_r, acc_r + cur_rd};
    rrng_ra = idx_r[NW-1:0];
    fin_we = 1'b0; fin_wa = fcount_r[NW-1:0]; fin_wd = tos_v_r;
    fin_ra = NW'(j_r - NCW'(1));
    root_we = 1'b0; root_wa = tgt_u; root_wd = root_r;
    root_ra = in_item.query_index[NW-1:0];
    topo_we = 1'b0; topo_wa = comp_r[NW-1:0]; topo_wd = fin_rd;
    topo_ra = in_item.query_index[NW-1:0];
    stk_we = 1'b0; stk_wa = NW'(sp_r - NCW'(1)); stk_wd = {tos_v_r, tos_pos_r, tos_end_r};
    stk_ra = NW'(sp_r - NCW'(2));
    pair_we = 1'b0; pair_wa = pclr_r[PAW-1:0]; pair_wd = 1'b0; pair_ra = {rv_r, root_rd};

    if (cfg_we) begin
      if (cfg_index == scc_pkg::CFG_NODE_COUNT) begin
        node_count_nxt = cfg_wdata;
      end else begin
        dedup_nxt = cfg_wdata[0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          qv_nxt  = 1'b1;
          qop_nxt = in_item.opcode;
          qst_nxt = scc_pkg::ST_OK;
          qcc_nxt = comp_r;
          qce_nxt = cond_r;
          case (in_item.opcode)
            scc_pkg::OP_CLEAR: begin
              edges_nxt = '0;
              comp_nxt  = '0;
              cond_nxt  = '0;
              ncomp_nxt = '0;
              qcc_nxt   = '0;
              qce_nxt   = '0;
            end
            scc_pkg::OP_ADD: begin
              if (({1'b0, in_item.edge_src} >= n_act) || ({1'b0, in_item.edge_dst} >= n_act)
                  || (edges_r >= ECW'(scc_pkg::EDGES))) begin
                qst_nxt = scc_pkg::ST_RANGE;
              end else begin
                edge_we   = 1'b1;
                edges_nxt = edges_r + ECW'(1);
              end
            end
            scc_pkg::OP_COMPUTE: begin
              qv_nxt    = 1'b0;
              rev_nxt   = 1'b0;
              idx_nxt   = '0;
              comp_nxt  = '0;
              cond_nxt  = '0;
              state_nxt = S_CCLR;
            end
            scc_pkg::OP_ROOT: begin
              if (in_item.query_index >= 9'(ncomp_r)) begin
                qst_nxt = scc_pkg::ST_RANGE;
              end
            end
            scc_pkg::OP_ORDER: begin
              if (in_item.query_index >= 9'(comp_r)) begin
                qst_nxt = scc_pkg::ST_INDEX;
              end
            end
            scc_pkg::OP_COND: begin
              if ({1'b0, in_item.query_index} >= cond_r) begin
                qst_nxt = scc_pkg::ST_INDEX;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CCLR: begin
        cur_we  = 1'b1;
        cur_wa  = idx_r[NW-1:0];
        cur_wd  = '0;
        idx_nxt = idx_r + NCW'(1);
        if (idx_r == NCW'(scc_pkg::NODES - 1)) begin
          e_nxt     = '0;
          state_nxt = S_CNT_A;
        end
      end
      S_CNT_A: begin
        if (e_r == lim) begin
          idx_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = S_PFX_A;
        end else begin
          state_nxt = S_CNT_B;
        end
      end
      S_CNT_B: begin
        if (cnt_ok) begin
          cur_ra    = cnt_key;
          key_nxt   = cnt_key;
          state_nxt = S_CNT_C;
        end else begin
          e_nxt     = e_r + ECW'(1);
          state_nxt = S_CNT_A;
        end
      end
      S_CNT_C: begin
        cur_we    = 1'b1;
        e_nxt     = e_r + ECW'(1);
        state_nxt = S_CNT_A;
      end
      S_PFX_A: begin
        if (idx_r == n_act) begin
          if (!rev_r) begin
            total_nxt = acc_r;
          end
          e_nxt     = '0;
          state_nxt = S_FIL_A;
        end else begin
          state_nxt = S_PFX_B;
        end
      end
      S_PFX_B: begin
        frng_we   = !rev_r;
        rrng_we   = rev_r;
        cur_we    = 1'b1;
        cur_wa    = idx_r[NW-1:0];
        cur_wd    = acc_r;
        acc_nxt   = acc_r + cur_rd;
        idx_nxt   = idx_r + NCW'(1);
        state_nxt = S_PFX_A;
      end
      S_FIL_A: begin
        if (e_r == lim) begin
          idx_nxt = '0;
          if (!rev_r) begin
            rev_nxt   = 1'b1;
            state_nxt = S_CCLR;
          end else begin
            rev_nxt    = 1'b0;
            fcount_nxt = '0;
            vis_nxt    = '0;
            pclr_nxt   = '0;
            state_nxt  = dedup_r ? S_PCLR : S_OUTF;
          end
        end else begin
          state_nxt = S_FIL_B;
        end
      end
      S_FIL_B: begin
        if (cnt_ok) begin
          cur_ra    = cnt_key;
          key_nxt   = cnt_key;
          s_nxt     = fil_s;
          d_nxt     = fil_d;
          state_nxt = S_FIL_C;
        end else begin
          e_nxt     = e_r + ECW'(1);
          state_nxt = S_FIL_A;
        end
      end
      S_FIL_C: begin
        fwd_we    = !rev_r;
        rev_we    = rev_r;
        cur_we    = 1'b1;
        e_nxt     = e_r + ECW'(1);
        state_nxt = S_FIL_A;
      end
      S_PCLR: begin
        pair_we  = 1'b1;
        pclr_nxt = pclr_r + (PAW+1)'(1);
        if (pclr_r == (PAW+1)'(scc_pkg::PAIRS - 1)) begin
          state_nxt = S_OUTF;
        end
      end
      S_OUTF: begin
        if (idx_r == n_act) begin
          vis_nxt   = '0;
          j_nxt     = fcount_r;
          rev_nxt   = 1'b1;
          state_nxt = S_OUTR_A;
        end else if (vis_r[idx_r[NW-1:0]]) begin
          idx_nxt = idx_r + NCW'(1);
        end else begin
          vis_nxt[idx_r[NW-1:0]] = 1'b1;
          tos_v_nxt = idx_r[NW-1:0];
          frng_ra   = idx_r[NW-1:0];
          sp_nxt    = '0;
          state_nxt = S_W_PUSH;
        end
      end
      S_OUTR_A: begin
        if (j_r == '0) begin
          idx_nxt   = '0;
          state_nxt = S_C_NODE;
        end else begin
          state_nxt = S_OUTR_B;
        end
      end
      S_OUTR_B: begin
        if (vis_r[fin_rd]) begin
          j_nxt     = j_r - NCW'(1);
          state_nxt = S_OUTR_A;
        end else begin
          // The first node reached in decreasing finish order names its component.
          vis_nxt[fin_rd] = 1'b1;
          root_we   = 1'b1;
          root_wa   = fin_rd;
          root_wd   = fin_rd;
          topo_we   = 1'b1;
          comp_nxt  = comp_r + NCW'(1);
          root_nxt  = fin_rd;
          tos_v_nxt = fin_rd;
          rrng_ra   = fin_rd;
          sp_nxt    = '0;
          state_nxt = S_W_PUSH;
        end
      end
      S_W_PUSH: begin
        tos_pos_nxt = rng_rd[2*ECW-1:ECW];
        tos_end_nxt = rng_rd[ECW-1:0];
        sp_nxt      = sp_r + NCW'(1);
        state_nxt   = S_W_TOP;
      end
      S_W_TOP: begin
        if (tos_pos_r < tos_end_r) begin
          fwd_ra      = tos_pos_r[EAW-1:0];
          tos_pos_nxt = tos_pos_r + ECW'(1);
          state_nxt   = S_W_TGT;
        end else begin
          if (!rev_r && (fcount_r < NCW'(scc_pkg::NODES))) begin
            fin_we     = 1'b1;
            fcount_nxt = fcount_r + NCW'(1);
          end
          sp_nxt = sp_r - NCW'(1);
          if (sp_r == NCW'(1)) begin
            if (rev_r) begin
              j_nxt     = j_r - NCW'(1);
              state_nxt = S_OUTR_A;
            end else begin
              idx_nxt   = idx_r + NCW'(1);
              state_nxt = S_OUTF;
            end
          end else begin
            state_nxt = S_W_POP;
          end
        end
      end
      S_W_TGT: begin
        if (!vis_r[tgt_u] && (sp_r < NCW'(scc_pkg::NODES))) begin
          vis_nxt[tgt_u] = 1'b1;
          root_we   = rev_r;
          stk_we    = 1'b1;
          frng_ra   = tgt_u;
          rrng_ra   = tgt_u;
          tos_v_nxt = tgt_u;
          state_nxt = S_W_PUSH;
        end else begin
          state_nxt = S_W_TOP;
        end
      end
      S_W_POP: begin
        tos_v_nxt   = stk_rd[SKW-1:2*ECW];
        tos_pos_nxt = stk_rd[2*ECW-1:ECW];
        tos_end_nxt = stk_rd[ECW-1:0];
        state_nxt   = S_W_TOP;
      end
      S_C_NODE: begin
        if (idx_r == n_act) begin
          state_nxt = S_DONE;
        end else begin
          root_ra   = idx_r[NW-1:0];
          state_nxt = S_C_NODE2;
        end
      end
      S_C_NODE2: begin
        rv_nxt    = root_rd;
        p_nxt     = frng_rd[2*ECW-1:ECW];
        pend_nxt  = frng_rd[ECW-1:0];
        state_nxt = S_C_EDGE;
      end
      S_C_EDGE: begin
        if (p_r == pend_r) begin
          idx_nxt   = idx_r + NCW'(1);
          state_nxt = S_C_NODE;
        end else begin
          fwd_ra    = p_r[EAW-1:0];
          p_nxt     = p_r + ECW'(1);
          state_nxt = S_C_DST;
        end
      end
      S_C_DST: begin
        root_ra   = fwd_rd[NW-1:0];
        state_nxt = S_C_CMP;
      end
      S_C_CMP: begin
        ru_nxt    = root_rd;
        state_nxt = S_C_EDGE;
        if (rv_r != root_rd) begin
          if (dedup_r) begin
            state_nxt = S_C_PAIR;
          end else if (cond_r < ECW'(scc_pkg::EDGES)) begin
            cond_we  = 1'b1;
            cond_wd  = {rv_r, root_rd};
            cond_nxt = cond_r + ECW'(1);
          end
        end
      end
      S_C_PAIR: begin
        state_nxt = S_C_EDGE;
        if (!pair_rd) begin
          pair_we = 1'b1;
          pair_wa = {rv_r, ru_r};
          pair_wd = 1'b1;
          if (cond_r < ECW'(scc_pkg::EDGES)) begin
            cond_we  = 1'b1;
            cond_nxt = cond_r + ECW'(1);
          end
        end
      end
      S_DONE: begin
        ncomp_nxt = n_act;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register: read data arrives in the cycle after the item was taken.
  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (qv_r) begin
      out_valid_nxt           = 1'b1;
      out_nxt.status          = qst_r;
      out_nxt.node_a          = '0;
      out_nxt.node_b          = '0;
      out_nxt.component_count = qcc_r;
      out_nxt.cond_edge_count = qce_r;
      if (qst_r == scc_pkg::ST_OK) begin
        case (qop_r)
          scc_pkg::OP_ROOT:  out_nxt.node_a = root_rd;
          scc_pkg::OP_ORDER: out_nxt.node_a = topo_rd;
          scc_pkg::OP_COND: begin
            out_nxt.node_a = cond_rd[2*NW-1:NW];
            out_nxt.node_b = cond_rd[NW-1:0];
          end
          default: begin
          end
        endcase
      end
    end else if (state_r == S_DONE) begin
      out_valid_nxt           = 1'b1;
      out_nxt.status          = scc_pkg::ST_OK;
      out_nxt.node_a          = '0;
      out_nxt.node_b          = '0;
      out_nxt.component_count = comp_r;
      out_nxt.cond_edge_count = cond_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NCW'(scc_pkg::NODES);
      dedup_r      <= 1'b0;
      edges_r      <= '0;
      comp_r       <= '0;
      cond_r       <= '0;
      ncomp_r      <= '0;
      rev_r        <= 1'b0;
      idx_r        <= '0;
      e_r          <= '0;
      j_r          <= '0;
      fcount_r     <= '0;
      vis_r        <= '0;
      sp_r         <= '0;
      pclr_r       <= '0;
      qv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      dedup_r      <= dedup_nxt;
      edges_r      <= edges_nxt;
      comp_r       <= comp_nxt;
      cond_r       <= cond_nxt;
      ncomp_r      <= ncomp_nxt;
      rev_r        <= rev_nxt;
      idx_r        <= idx_nxt;
      e_r          <= e_nxt;
      j_r          <= j_nxt;
      fcount_r     <= fcount_nxt;
      vis_r        <= vis_nxt;
      sp_r         <= sp_nxt;
      pclr_r       <= pclr_nxt;
      qv_r         <= qv_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    total_r   <= total_nxt;
    key_r     <= key_nxt;
    s_r       <= s_nxt;
    d_r       <= d_nxt;
    tos_v_r   <= tos_v_nxt;
    tos_pos_r <= tos_pos_nxt;
    tos_end_r <= tos_end_nxt;
    root_r    <= root_nxt;
    rv_r      <= rv_nxt;
    ru_r      <= ru_nxt;
    p_r       <= p_nxt;
    pend_r    <= pend_nxt;
    qop_r     <= qop_nxt;
    qst_r     <= qst_nxt;
    qcc_r     <= qcc_nxt;
    qce_r     <= qce_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef NO_ASSERTIONS
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= NCW'(scc_pkg::NODES))
    else $error("walk stack deeper than the node count");
  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W_TOP || state_r == S_W_TGT) |-> sp_r != '0)
    else $error("walk step with an empty stack");
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (out_valid_r && state_r == S_IDLE))
    else $error("compute finished without a result beat");
  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edges_r <= ECW'(scc_pkg::EDGES) && cond_r <= ECW'(scc_pkg::EDGES))
    else $error("edge count beyond table size");
`endif
endmodule
`default_nettype wire
